FILE: sv/assert_macros.svh
// assertion helpers used by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define CHK_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rgbpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbpf_pkg;

    localparam int NUM_CH         = 3;
    localparam int LEVEL_W        = 5;
    localparam int ELAPSED_W      = 24;
    localparam int STEP_W         = 8;
    localparam int SLOT_W         = 8;
    localparam int RULE_W         = STEP_W + ELAPSED_W;
    localparam int SEC_PROD_W     = 18;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 6;
    localparam int IN_DATA_W      = 56;
    localparam int OUT_DATA_W     = 24;
    localparam int MAX_LEVEL      = 31;
    localparam int MS_PER_SECOND  = 1000;
    localparam int SEC_PER_MINUTE = 60;
    localparam int MS_PER_MINUTE  = MS_PER_SECOND * SEC_PER_MINUTE;

    typedef enum logic [2:0] {
        REQ_SLOT_TICK  = 3'd0,
        REQ_MS_TICK    = 3'd1,
        REQ_WRITE_RULE = 3'd2,
        REQ_WRITE_SLOT = 3'd3,
        REQ_SET_LEVEL  = 3'd4
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_START    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_START  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_FADE,
        ST_RULE_MUL,
        ST_RULE_WR,
        ST_EXEC,
        ST_FIN
    } t_eng_state;

    // request payload, first field in the highest bits
    typedef struct packed {
        logic [7:0] new_level;
        logic [7:0] slot_value;
        logic [7:0] rule_millis;
        logic [7:0] rule_seconds;
        logic [7:0] rule_minutes;
        logic [7:0] rule_step;
        logic [5:0] entry_index;
        logic [1:0] channel;
    } t_in_data;

    typedef struct packed {
        logic [5:0]         pad;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [LEVEL_W-1:0] red_level;
        logic [2:0]         led_bits;
    } t_out_data;

    typedef struct packed {
        logic                 active;
        logic [LEVEL_W-1:0]   level;
        logic [ELAPSED_W-1:0] elapsed;
        logic [STEP_W-1:0]    step;
        logic [ELAPSED_W-1:0] interval;
    } t_fade_in;

    typedef struct packed {
        logic                 fire;
        logic [LEVEL_W-1:0]   level;
        logic [ELAPSED_W-1:0] elapsed;
    } t_fade_out;

endpackage

`default_nettype wire

FILE: sv/rgbpf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/rgbpf_fade_step.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbpf_fade_step #(
    parameter int LEVEL_COUNT = 32
) (
    input  wire rgbpf_pkg::t_fade_in  i_in,
    output rgbpf_pkg::t_fade_out      o_out
);

    localparam int SUM_W = rgbpf_pkg::STEP_W + 2;

    logic [rgbpf_pkg::ELAPSED_W-1:0] el_inc;
    logic [SUM_W-1:0]                lvl_ext;
    logic [SUM_W-1:0]                step_ext;
    logic [SUM_W-1:0]                sum;
    logic                            sum_ok;
    logic                            fire;

    always_comb begin
        // elapsed time saturates at its top value
        el_inc   = (&i_in.elapsed) ? i_in.elapsed : i_in.elapsed + 1'b1;
        lvl_ext  = {{(SUM_W - rgbpf_pkg::LEVEL_W){1'b0}}, i_in.level};
        step_ext = {{(SUM_W - rgbpf_pkg::STEP_W){i_in.step[rgbpf_pkg::STEP_W-1]}}, i_in.step};
        sum      = lvl_ext + step_ext;
        sum_ok   = !sum[SUM_W-1] && (sum <= SUM_W'(rgbpf_pkg::MAX_LEVEL))
                   && (sum < SUM_W'(LEVEL_COUNT));
        fire     = i_in.active && (el_inc >= i_in.interval);

        o_out.fire    = fire;
        o_out.level   = (fire && sum_ok) ? sum[rgbpf_pkg::LEVEL_W-1:0] : i_in.level;
        if (!i_in.active) begin
            o_out.elapsed = i_in.elapsed;
        end else if (fire) begin
            o_out.elapsed = '0;
        end else begin
            o_out.elapsed = el_inc;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rgb_pwm_fade_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Three-channel LED PWM with a rule-driven fade sequencer. Each request on the slave stream
// returns one result holding the LED drive and the three channel levels. Once a request
// reaches the engine, a slot tick makes three reads of the slot table through its one
// read port, one per channel; a millisecond tick makes three reads of the rule memory, one
// per channel, each followed by the level and elapsed update; a rule write does the
// interval multiply, then the memory write; other requests run a single execute step.
// A one-entry input buffer takes the next request while the engine works and an
// output register holds the result until the master side takes it. Rule and slot tables
// come out of reset unwritten and are not cleared; configuration writes apply at once and
// must come while the block is idle.
module rgb_pwm_fade_sequencer #(
    parameter int RULE_COUNT  = 64,
    parameter int LEVEL_COUNT = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // channel, entry_index, rule_step, rule_minutes, rule_seconds, rule_millis,
    // slot_value, new_level
    input  wire logic [rgbpf_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // req_type
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // led_bits, red_level, blue_level, green_level, zero fill
    output logic [rgbpf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [rgbpf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rgbpf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RULE_AW = $clog2(RULE_COUNT);
    localparam int SLOT_AW = $clog2(LEVEL_COUNT);
    localparam int PC_W    = RULE_AW + 1;
    localparam int CMP_W   = 9;
    localparam int NCH     = rgbpf_pkg::NUM_CH;
    localparam int LW      = rgbpf_pkg::LEVEL_W;
    localparam int EW      = rgbpf_pkg::ELAPSED_W;

    function automatic logic [RULE_AW-1:0] clamp_pos(input logic [rgbpf_pkg::CFG_DATA_W-1:0] p);
        return ({3'b000, p} < CMP_W'(RULE_COUNT)) ? RULE_AW'(p) : '0;
    endfunction

    function automatic rgbpf_pkg::t_eng_state first_state(input logic [2:0] req);
        rgbpf_pkg::t_eng_state s;
        case (req)
            rgbpf_pkg::REQ_SLOT_TICK:  s = rgbpf_pkg::ST_SLOT;
            rgbpf_pkg::REQ_MS_TICK:    s = rgbpf_pkg::ST_FADE;
            rgbpf_pkg::REQ_WRITE_RULE: s = rgbpf_pkg::ST_RULE_MUL;
            default:                   s = rgbpf_pkg::ST_EXEC;
        endcase
        return s;
    endfunction

    // configuration
    logic                r_fade_en, n_fade_en;
    logic [NCH-1:0]      r_mask, n_mask;

    // per channel state
    logic [LW-1:0]       r_level   [NCH];
    logic [LW-1:0]       n_level   [NCH];
    logic [RULE_AW-1:0]  r_pos     [NCH];
    logic [RULE_AW-1:0]  n_pos     [NCH];
    logic [EW-1:0]       r_elapsed [NCH];
    logic [EW-1:0]       n_elapsed [NCH];
    logic [7:0]          r_slot_cnt, n_slot_cnt;
    logic [NCH-1:0]      r_led, n_led;
    logic [1:0]          r_led_acc, n_led_acc;

    // stream buffers
    logic                    r_in_valid;
    logic [2:0]              r_in_req;
    rgbpf_pkg::t_in_data     r_in_data;
    logic [2:0]              r_job_req;
    rgbpf_pkg::t_in_data     r_job;
    logic                    r_out_valid;
    rgbpf_pkg::t_out_data    r_out_data;

    // engine
    rgbpf_pkg::t_eng_state   r_state, n_state;
    logic [1:0]              r_sub, n_sub;
    logic [EW-1:0]           r_prod_min, n_prod_min;
    logic [rgbpf_pkg::SEC_PROD_W-1:0] r_prod_sec, n_prod_sec;

    logic                    in_acc;
    logic                    out_free;
    logic                    take;
    logic                    fin_go;
    logic [1:0]              proc_ch;
    logic [PC_W-1:0]         pos_inc;
    logic [RULE_AW-1:0]      pos_next;
    logic                    slot_bit;

    logic                    rule_we;
    logic [RULE_AW-1:0]      rule_waddr;
    logic [rgbpf_pkg::RULE_W-1:0] rule_wdata;
    logic [RULE_AW-1:0]      rule_raddr;
    logic [rgbpf_pkg::RULE_W-1:0] rule_rdata;
    logic                    slot_we;
    logic [SLOT_AW-1:0]      slot_waddr;
    logic [rgbpf_pkg::SLOT_W-1:0] slot_wdata;
    logic [SLOT_AW-1:0]      slot_raddr;
    logic [rgbpf_pkg::SLOT_W-1:0] slot_rdata;

    rgbpf_pkg::t_fade_in     fade_in;
    rgbpf_pkg::t_fade_out    fade_out;

    assign in_acc          = i_s_axis_tvalid && !r_in_valid;
    assign o_s_axis_tready = !r_in_valid;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fin_go          = (r_state == rgbpf_pkg::ST_FIN) && out_free;
    assign take            = r_in_valid && ((r_state == rgbpf_pkg::ST_IDLE) || fin_go);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    rgbpf_ram #(
        .WIDTH (rgbpf_pkg::RULE_W),
        .DEPTH (RULE_COUNT)
    ) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (rule_we),
        .i_waddr (rule_waddr),
        .i_wdata (rule_wdata),
        .i_raddr (rule_raddr),
        .o_rdata (rule_rdata)
    );

    rgbpf_ram #(
        .WIDTH (rgbpf_pkg::SLOT_W),
        .DEPTH (LEVEL_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    rgbpf_fade_step #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_fade_step (
        .i_in  (fade_in),
        .o_out (fade_out)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rgbpf_pkg::ST_IDLE: begin
                if (r_in_valid) begin
                    n_state = first_state(r_in_req);
                end
            end
            rgbpf_pkg::ST_SLOT,
            rgbpf_pkg::ST_FADE: begin
                if (r_sub == 2'd3) begin
                    n_state = rgbpf_pkg::ST_FIN;
                end
            end
            rgbpf_pkg::ST_RULE_MUL: n_state = rgbpf_pkg::ST_RULE_WR;
            rgbpf_pkg::ST_RULE_WR:  n_state = rgbpf_pkg::ST_FIN;
            rgbpf_pkg::ST_EXEC:     n_state = rgbpf_pkg::ST_FIN;
            rgbpf_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = r_in_valid ? first_state(r_in_req) : rgbpf_pkg::ST_IDLE;
                end
            end
            default: n_state = rgbpf_pkg::ST_IDLE;
        endcase
    end

    // channel handled in the current fade or slot step
    always_comb begin
        case (r_sub)
            2'd1:    proc_ch = 2'd0;
            2'd2:    proc_ch = 2'd1;
            default: proc_ch = 2'd2;
        endcase
    end

    // engine outputs and state updates
    always_comb begin
        n_fade_en  = r_fade_en;
        n_mask     = r_mask;
        n_level    = r_level;
        n_pos      = r_pos;
        n_elapsed  = r_elapsed;
        n_slot_cnt = r_slot_cnt;
        n_led      = r_led;
        n_led_acc  = r_led_acc;
        n_prod_min = r_prod_min;
        n_prod_sec = r_prod_sec;
        n_sub      = ((r_state == rgbpf_pkg::ST_SLOT) || (r_state == rgbpf_pkg::ST_FADE))
                     ? r_sub + 2'd1 : 2'd0;

        rule_we    = 1'b0;
        rule_waddr = RULE_AW'(r_job.entry_index);
        rule_wdata = {r_job.rule_step,
                      r_prod_min + EW'(r_prod_sec) + EW'(r_job.rule_millis)};
        slot_we    = 1'b0;
        slot_waddr = SLOT_AW'(r_job.entry_index);
        slot_wdata = r_job.slot_value;

        // one table read per channel, issued in the cycle before its use
        case (r_sub)
            2'd0: begin
                rule_raddr = r_pos[0];
                slot_raddr = SLOT_AW'(r_level[0]);
            end
            2'd1: begin
                rule_raddr = r_pos[1];
                slot_raddr = SLOT_AW'(r_level[1]);
            end
            default: begin
                rule_raddr = r_pos[2];
                slot_raddr = SLOT_AW'(r_level[2]);
            end
        endcase

        fade_in.active   = (r_state == rgbpf_pkg::ST_FADE) && (r_sub != 2'd0)
                           && r_fade_en && r_mask[proc_ch];
        fade_in.level    = r_level[proc_ch];
        fade_in.elapsed  = r_elapsed[proc_ch];
        fade_in.step     = rule_rdata[rgbpf_pkg::RULE_W-1:EW];
        fade_in.interval = rule_rdata[EW-1:0];

        pos_inc  = {1'b0, r_pos[proc_ch]} + 1'b1;
        pos_next = (pos_inc == PC_W'(RULE_COUNT)) ? '0 : pos_inc[RULE_AW-1:0];
        slot_bit = r_slot_cnt < slot_rdata;

        case (r_state)
            rgbpf_pkg::ST_SLOT: begin
                case (r_sub)
                    2'd0:    n_slot_cnt = r_slot_cnt + 8'd1;
                    2'd1:    n_led_acc[0] = slot_bit;
                    2'd2:    n_led_acc[1] = slot_bit;
                    default: n_led = {slot_bit, r_led_acc};
                endcase
            end
            rgbpf_pkg::ST_FADE: begin
                if (r_sub != 2'd0) begin
                    n_level[proc_ch]   = fade_out.level;
                    n_elapsed[proc_ch] = fade_out.elapsed;
                    if (fade_out.fire) begin
                        n_pos[proc_ch] = pos_next;
                    end
                end
            end
            rgbpf_pkg::ST_RULE_MUL: begin
                n_prod_min = EW'(r_job.rule_minutes) * EW'(rgbpf_pkg::MS_PER_MINUTE);
                n_prod_sec = rgbpf_pkg::SEC_PROD_W'(r_job.rule_seconds)
                             * rgbpf_pkg::SEC_PROD_W'(rgbpf_pkg::MS_PER_SECOND);
            end
            rgbpf_pkg::ST_RULE_WR: begin
                rule_we = {3'b000, r_job.entry_index} < CMP_W'(RULE_COUNT);
            end
            rgbpf_pkg::ST_EXEC: begin
                case (r_job_req)
                    rgbpf_pkg::REQ_WRITE_SLOT: begin
                        slot_we = {3'b000, r_job.entry_index} < CMP_W'(LEVEL_COUNT);
                    end
                    rgbpf_pkg::REQ_SET_LEVEL: begin
                        if ((r_job.channel != 2'd3)
                            && ({1'b0, r_job.new_level} <= CMP_W'(rgbpf_pkg::MAX_LEVEL))
                            && ({1'b0, r_job.new_level} < CMP_W'(LEVEL_COUNT))) begin
                            n_level[r_job.channel] = r_job.new_level[LW-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                rgbpf_pkg::CFG_FADE_ENABLE:  n_fade_en = i_cfg_data[0];
                rgbpf_pkg::CFG_CHANNEL_MASK: n_mask = i_cfg_data[NCH-1:0];
                rgbpf_pkg::CFG_RED_START: begin
                    n_pos[0]     = clamp_pos(i_cfg_data);
                    n_elapsed[0] = '0;
                end
                rgbpf_pkg::CFG_BLUE_START: begin
                    n_pos[1]     = clamp_pos(i_cfg_data);
                    n_elapsed[1] = '0;
                end
                rgbpf_pkg::CFG_GREEN_START: begin
                    n_pos[2]     = clamp_pos(i_cfg_data);
                    n_elapsed[2] = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rgbpf_pkg::ST_IDLE;
            r_sub       <= 2'd0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fade_en   <= 1'b1;
            r_mask      <= 3'b111;
            r_slot_cnt  <= 8'd0;
            r_led       <= '0;
            r_pos[0]    <= clamp_pos(6'd0);
            r_pos[1]    <= clamp_pos(6'd21);
            r_pos[2]    <= clamp_pos(6'd42);
            for (int i = 0; i < NCH; i++) begin
                r_level[i]   <= '0;
                r_elapsed[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_sub      <= n_sub;
            r_fade_en  <= n_fade_en;
            r_mask     <= n_mask;
            r_slot_cnt <= n_slot_cnt;
            r_led      <= n_led;
            r_level    <= n_level;
            r_pos      <= n_pos;
            r_elapsed  <= n_elapsed;
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_led_acc  <= n_led_acc;
        r_prod_min <= n_prod_min;
        r_prod_sec <= n_prod_sec;
        if (in_acc) begin
            r_in_req  <= i_s_axis_tuser;
            r_in_data <= rgbpf_pkg::t_in_data'(i_s_axis_tdata);
        end
        if (take) begin
            r_job_req <= r_in_req;
            r_job     <= r_in_data;
        end
        if (fin_go) begin
            r_out_data.pad         <= '0;
            r_out_data.green_level <= r_level[2];
            r_out_data.blue_level  <= r_level[1];
            r_out_data.red_level   <= r_level[0];
            r_out_data.led_bits    <= r_led;
        end
    end

    `CHK_ALWAYS(a_level_valid, (int'(r_level[0]) < LEVEL_COUNT) && (int'(r_level[1]) < LEVEL_COUNT) && (int'(r_level[2]) < LEVEL_COUNT), "level beyond level count")

    `CHK_NEXT(a_result_loaded, fin_go, r_out_valid, "finished request left no result")

    `CHK_NEXT(a_start_clears, i_cfg_we && (i_cfg_index == rgbpf_pkg::CFG_RED_START), r_elapsed[0] == '0, "start rule write kept elapsed time")

    `CHK_NEXT(a_slot_advance, (r_state == rgbpf_pkg::ST_SLOT) && (r_sub == 2'd0), r_slot_cnt == $past(r_slot_cnt) + 8'd1, "slot counter did not advance")

endmodule

`default_nettype wire
